// ----- rtl/core/pl0lex_pkg.sv -----
// Shared types, token and status codes, and keyword tables for the PL/0 lexer.
package pl0lex_pkg;

    // Longest keyword and the most digits a number accumulator keeps
    localparam int KW_MAX_LEN     = 9;
    localparam int NUM_MAX_DIGITS = 9;

    // Token codes
    localparam logic [5:0] TOK_NONE    = 6'd0;
    localparam logic [5:0] TOK_SKIP    = 6'd1;
    localparam logic [5:0] TOK_IDENT   = 6'd2;
    localparam logic [5:0] TOK_NUMBER  = 6'd3;
    localparam logic [5:0] TOK_PLUS    = 6'd4;
    localparam logic [5:0] TOK_MINUS   = 6'd5;
    localparam logic [5:0] TOK_TIMES   = 6'd6;
    localparam logic [5:0] TOK_SLASH   = 6'd7;
    localparam logic [5:0] TOK_IFEL    = 6'd8;
    localparam logic [5:0] TOK_EQ      = 6'd9;
    localparam logic [5:0] TOK_NE      = 6'd10;
    localparam logic [5:0] TOK_LT      = 6'd11;
    localparam logic [5:0] TOK_LE      = 6'd12;
    localparam logic [5:0] TOK_GT      = 6'd13;
    localparam logic [5:0] TOK_GE      = 6'd14;
    localparam logic [5:0] TOK_LPAREN  = 6'd15;
    localparam logic [5:0] TOK_RPAREN  = 6'd16;
    localparam logic [5:0] TOK_COMMA   = 6'd17;
    localparam logic [5:0] TOK_SEMI    = 6'd18;
    localparam logic [5:0] TOK_PERIOD  = 6'd19;
    localparam logic [5:0] TOK_BECOMES = 6'd20;
    localparam logic [5:0] TOK_BEGIN   = 6'd21;
    localparam logic [5:0] TOK_END     = 6'd22;
    localparam logic [5:0] TOK_IF      = 6'd23;
    localparam logic [5:0] TOK_THEN    = 6'd24;
    localparam logic [5:0] TOK_WHILE   = 6'd25;
    localparam logic [5:0] TOK_DO      = 6'd26;
    localparam logic [5:0] TOK_CALL    = 6'd27;
    localparam logic [5:0] TOK_CONST   = 6'd28;
    localparam logic [5:0] TOK_VAR     = 6'd29;
    localparam logic [5:0] TOK_PROC    = 6'd30;
    localparam logic [5:0] TOK_WRITE   = 6'd31;
    localparam logic [5:0] TOK_READ    = 6'd32;
    localparam logic [5:0] TOK_ELSE    = 6'd33;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NAME_LONG    = 3'd1;
    localparam logic [2:0] ST_NUM_LONG     = 3'd2;
    localparam logic [2:0] ST_BAD_SYMBOL   = 3'd3;
    localparam logic [2:0] ST_OPEN_COMMENT = 3'd4;

    // Configuration register indexes and reset values
    localparam logic       CFG_IDENT_MAX  = 1'b0;
    localparam logic       CFG_NUMBER_MAX = 1'b1;
    localparam logic [5:0] IDENT_MAX_RESET  = 6'd11;
    localparam logic [3:0] NUMBER_MAX_RESET = 4'd5;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } char_item_t;

    typedef struct packed {
        logic [5:0]  token_code;
        logic [2:0]  status;
        logic [7:0]  lexeme_length;
        logic [29:0] number_value;
        logic        last_of_run;
    } token_item_t;

    typedef struct packed {
        logic [5:0] ident_max_len;
        logic [3:0] number_max_digits;
    } cfg_t;

    // Results of one accepted item, in delivery order
    typedef struct packed {
        logic [1:0]  count;
        token_item_t first;
        token_item_t second;
    } push_t;

    typedef struct packed {
        logic room;
    } fifo_status_t;

    typedef logic [0:KW_MAX_LEN-1][7:0] kw_text_t;

    function automatic token_item_t make_token(input logic [5:0] code, input logic [2:0] st,
                                               input logic [7:0] len, input logic [29:0] value);
        token_item_t t;
        t.token_code    = code;
        t.status        = st;
        t.lexeme_length = len;
        t.number_value  = value;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            "+":     code = TOK_PLUS;
            "-":     code = TOK_MINUS;
            "*":     code = TOK_TIMES;
            "/":     code = TOK_SLASH;
            "=":     code = TOK_EQ;
            "<":     code = TOK_LT;
            ">":     code = TOK_GT;
            "(":     code = TOK_LPAREN;
            ")":     code = TOK_RPAREN;
            ",":     code = TOK_COMMA;
            ";":     code = TOK_SEMI;
            ".":     code = TOK_PERIOD;
            default: code = TOK_NONE;
        endcase
        return code;
    endfunction

    function automatic token_item_t single_token(input logic [7:0] c);
        logic [5:0] code;
        code = single_code(c);
        return make_token(code, (code == TOK_NONE) ? ST_BAD_SYMBOL : ST_OK, 8'd1, 30'd0);
    endfunction

    // Keyword lookup; a length code of 15 stands for any word longer than nine
    function automatic logic [5:0] keyword_code(input logic [3:0] len, input kw_text_t t);
        logic [5:0] code;
        code = TOK_NONE;
        case (len)
            4'd2:
            begin
                if (t[0:1] == "if")      code = TOK_IF;
                else if (t[0:1] == "do") code = TOK_DO;
            end
            4'd3:
            begin
                if (t[0:2] == "end")      code = TOK_END;
                else if (t[0:2] == "var") code = TOK_VAR;
            end
            4'd4:
            begin
                if (t[0:3] == "skip")      code = TOK_SKIP;
                else if (t[0:3] == "ifel") code = TOK_IFEL;
                else if (t[0:3] == "then") code = TOK_THEN;
                else if (t[0:3] == "call") code = TOK_CALL;
                else if (t[0:3] == "read") code = TOK_READ;
                else if (t[0:3] == "else") code = TOK_ELSE;
            end
            4'd5:
            begin
                if (t[0:4] == "begin")      code = TOK_BEGIN;
                else if (t[0:4] == "while") code = TOK_WHILE;
                else if (t[0:4] == "const") code = TOK_CONST;
                else if (t[0:4] == "write") code = TOK_WRITE;
            end
            4'd9:
            begin
                if (t[0:8] == "procedure") code = TOK_PROC;
            end
            default: code = TOK_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/pl0lex_scanner.sv -----
// Scanner state and per-character next-state and token logic.
module pl0lex_scanner #(
    parameter int KEYWORD_CHARS = 9,
    parameter int LENGTH_LIMIT  = 255
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  pl0lex_pkg::char_item_t  item,
    input  pl0lex_pkg::cfg_t        cfg,
    output pl0lex_pkg::push_t       push
);

    localparam int CW  = $clog2(LENGTH_LIMIT + 1);
    localparam int LW  = (CW > 8) ? CW : 8;
    localparam int KIW = $clog2(KEYWORD_CHARS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(LENGTH_LIMIT);

    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_COLON   = 6'b000010,
        MODE_REL     = 6'b000100,
        MODE_SLASH   = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_STAR    = 6'b100000
    } mode_t;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'b001,
        CLS_WORD   = 3'b010,
        CLS_NUMBER = 3'b100
    } cls_t;

    mode_t       mode_reg, mode_next;
    cls_t        cls_reg, cls_next;
    logic [CW-1:0] count_reg, count_next;
    logic [29:0] accum_reg, accum_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  kw_reg [KEYWORD_CHARS];
    logic        kw_we;
    logic [KIW-1:0] kw_addr;

    logic [7:0] c;
    logic       eoi;
    logic       is_ws, is_letter, is_digit, is_other, is_special;
    logic       sn_en;

    pl0lex_pkg::kw_text_t    kw_text;
    logic [3:0]              kw_len;
    logic [5:0]              kw_code;
    logic [LW-1:0]           count_ext;
    logic [7:0]              lexeme_len;
    logic [3:0]              num_lim;
    logic                    name_ok, num_ok;
    pl0lex_pkg::token_item_t flush_tok, lead_tok, sym_tok;
    logic                    flush_v, lead_v, c1v, c2v;
    logic [5:0]              rel_code;

    cls_t          base_cls, new_cls;
    logic [CW-1:0] base_count;
    logic [29:0]   base_accum;
    logic [29:0]   accum_step;

    assign c   = item.char_in;
    assign eoi = item.end_of_input;

    always_comb
    begin
        is_ws      = (c == " ") || (c == 8'h09) || (c == 8'h0A);
        is_letter  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        is_digit   = (c >= "0") && (c <= "9");
        is_other   = !is_ws && !is_letter && !is_digit;
        is_special = (c == ":") || (c == "<") || (c == ">") || (c == "!") || (c == "/");
    end

    // Token for the pending word or number
    always_comb
    begin
        for (int i = 0; i < pl0lex_pkg::KW_MAX_LEN; i++)
        begin
            kw_text[i] = kw_reg[i];
        end
        kw_len     = (count_reg > CW'(pl0lex_pkg::KW_MAX_LEN)) ? 4'hF : count_reg[3:0];
        kw_code    = pl0lex_pkg::keyword_code(kw_len, kw_text);
        count_ext  = LW'(count_reg);
        lexeme_len = (count_ext > LW'(255)) ? 8'hFF : count_ext[7:0];
        num_lim    = (cfg.number_max_digits > 4'(pl0lex_pkg::NUM_MAX_DIGITS))
                   ? 4'(pl0lex_pkg::NUM_MAX_DIGITS) : cfg.number_max_digits;
        name_ok    = count_ext <= LW'(cfg.ident_max_len);
        num_ok     = count_ext <= LW'(num_lim);
        flush_v    = 1'b0;
        flush_tok  = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE, pl0lex_pkg::ST_OK,
                                            8'd0, 30'd0);
        case (cls_reg)
            CLS_WORD:
            begin
                flush_v = 1'b1;
                if (kw_code != pl0lex_pkg::TOK_NONE)
                    flush_tok = pl0lex_pkg::make_token(kw_code, pl0lex_pkg::ST_OK,
                                                       lexeme_len, 30'd0);
                else if (name_ok)
                    flush_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_IDENT,
                                                       pl0lex_pkg::ST_OK, lexeme_len, 30'd0);
                else
                    flush_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE,
                                                       pl0lex_pkg::ST_NAME_LONG,
                                                       lexeme_len, 30'd0);
            end
            CLS_NUMBER:
            begin
                flush_v = 1'b1;
                if (num_ok)
                    flush_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NUMBER,
                                                       pl0lex_pkg::ST_OK, lexeme_len,
                                                       accum_reg);
                else
                    flush_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE,
                                                       pl0lex_pkg::ST_NUM_LONG,
                                                       lexeme_len, 30'd0);
            end
            default: flush_v = 1'b0;
        endcase
    end

    // Lead token from a waiting symbol or from end of input
    always_comb
    begin
        rel_code = (held_reg == "<") ? pl0lex_pkg::TOK_LE
                 : (held_reg == ">") ? pl0lex_pkg::TOK_GE : pl0lex_pkg::TOK_NE;
        lead_v   = 1'b0;
        lead_tok = pl0lex_pkg::single_token(held_reg);
        if (eoi)
        begin
            case (mode_reg)
                MODE_COLON:
                begin
                    lead_v   = 1'b1;
                    lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE,
                                                      pl0lex_pkg::ST_BAD_SYMBOL, 8'd1, 30'd0);
                end
                MODE_REL: lead_v = 1'b1;
                MODE_SLASH:
                begin
                    lead_v   = 1'b1;
                    lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_SLASH,
                                                      pl0lex_pkg::ST_OK, 8'd1, 30'd0);
                end
                MODE_COMMENT, MODE_STAR:
                begin
                    lead_v   = 1'b1;
                    lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE,
                                                      pl0lex_pkg::ST_OPEN_COMMENT,
                                                      8'd0, 30'd0);
                end
                default:
                begin
                    lead_v   = flush_v;
                    lead_tok = flush_tok;
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_COLON:
                begin
                    lead_v = 1'b1;
                    if (c == "=")
                        lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_BECOMES,
                                                          pl0lex_pkg::ST_OK, 8'd2, 30'd0);
                    else
                        lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_NONE,
                                                          pl0lex_pkg::ST_BAD_SYMBOL,
                                                          8'd2, 30'd0);
                end
                MODE_REL:
                begin
                    lead_v = 1'b1;
                    if (c == "=")
                        lead_tok = pl0lex_pkg::make_token(rel_code, pl0lex_pkg::ST_OK,
                                                          8'd2, 30'd0);
                end
                MODE_SLASH:
                begin
                    lead_v   = (c != "*");
                    lead_tok = pl0lex_pkg::make_token(pl0lex_pkg::TOK_SLASH,
                                                      pl0lex_pkg::ST_OK, 8'd1, 30'd0);
                end
                default: lead_v = 1'b0;
            endcase
        end
    end

    // Normal scan of the byte, also after a relation or slash that did not join
    always_comb
    begin
        sn_en   = !eoi && ((mode_reg == MODE_NORMAL)
                        || ((mode_reg == MODE_REL) && (c != "="))
                        || ((mode_reg == MODE_SLASH) && (c != "*")));
        c1v     = sn_en && flush_v
                && (is_ws || is_other || (is_letter && (cls_reg == CLS_NUMBER)));
        c2v     = sn_en && is_other && !is_special;
        sym_tok = pl0lex_pkg::single_token(c);
    end

    // Pack up to two results in order and mark the final one
    always_comb
    begin
        push.first  = sym_tok;
        push.second = sym_tok;
        push.count  = 2'd0;
        if (lead_v)
        begin
            push.first  = lead_tok;
            push.second = c1v ? flush_tok : sym_tok;
            push.count  = (c1v || c2v) ? 2'd2 : 2'd1;
        end
        else if (c1v)
        begin
            push.first  = flush_tok;
            push.second = sym_tok;
            push.count  = c2v ? 2'd2 : 2'd1;
        end
        else if (c2v)
        begin
            push.count = 2'd1;
        end
        if (!step)
            push.count = 2'd0;
        if (push.count == 2'd2)
            push.second.last_of_run = 1'b1;
        else
            push.first.last_of_run = 1'b1;
    end

    // Next state
    always_comb
    begin
        mode_next  = mode_reg;
        cls_next   = cls_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        held_next  = held_reg;
        kw_we      = 1'b0;
        base_cls   = cls_reg;
        base_count = count_reg;
        base_accum = accum_reg;
        if (is_letter && (cls_reg == CLS_NUMBER))
        begin
            base_cls   = CLS_NONE;
            base_count = '0;
            base_accum = '0;
        end
        new_cls    = is_letter ? CLS_WORD : ((base_cls == CLS_NONE) ? CLS_NUMBER : base_cls);
        kw_addr    = base_count[KIW-1:0];
        accum_step = {base_accum[26:0], 3'b000} + {base_accum[28:0], 1'b0}
                   + {26'd0, c[3:0]};
        if (step)
        begin
            if (eoi)
            begin
                mode_next  = MODE_NORMAL;
                cls_next   = CLS_NONE;
                count_next = '0;
                accum_next = '0;
                held_next  = 8'd0;
            end
            else
            begin
                case (mode_reg)
                    MODE_COLON: mode_next = MODE_NORMAL;
                    MODE_REL:   mode_next = MODE_NORMAL;
                    MODE_SLASH: mode_next = (c == "*") ? MODE_COMMENT : MODE_NORMAL;
                    MODE_COMMENT:
                    begin
                        if (c == "*")
                            mode_next = MODE_STAR;
                    end
                    MODE_STAR:
                    begin
                        if (c == "/")
                            mode_next = MODE_NORMAL;
                        else if (c != "*")
                            mode_next = MODE_COMMENT;
                    end
                    default: mode_next = MODE_NORMAL;
                endcase
                if (sn_en)
                begin
                    if (is_ws || is_other)
                    begin
                        cls_next   = CLS_NONE;
                        count_next = '0;
                        accum_next = '0;
                        if (c == ":")
                            mode_next = MODE_COLON;
                        else if ((c == "<") || (c == ">") || (c == "!"))
                        begin
                            mode_next = MODE_REL;
                            held_next = c;
                        end
                        else if (c == "/")
                            mode_next = MODE_SLASH;
                    end
                    else
                    begin
                        cls_next   = new_cls;
                        accum_next = base_accum;
                        kw_we      = (new_cls == CLS_WORD)
                                   && (base_count < CW'(KEYWORD_CHARS));
                        if ((new_cls == CLS_NUMBER)
                            && (base_count < CW'(pl0lex_pkg::NUM_MAX_DIGITS)))
                            accum_next = accum_step;
                        count_next = (base_count < COUNT_MAX) ? base_count + CW'(1)
                                                              : base_count;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            cls_reg   <= CLS_NONE;
            count_reg <= '0;
            accum_reg <= '0;
            held_reg  <= 8'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            cls_reg   <= cls_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            held_reg  <= held_next;
        end
    end

    // Word text; only positions written for the current word are ever compared
    always_ff @(posedge clk)
    begin
        if (kw_we)
            kw_reg[kw_addr] <= c;
    end

endmodule

// ----- rtl/core/pl0lex_out_fifo.sv -----
// Four-entry result queue taking up to two tokens per cycle, giving one per cycle while tok_ready is high.
module pl0lex_out_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pl0lex_pkg::push_t        push,
    output logic                     tok_valid,
    input  logic                     tok_ready,
    output pl0lex_pkg::token_item_t  tok_item,
    output pl0lex_pkg::fifo_status_t status
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    pl0lex_pkg::token_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;
    logic          pop;

    assign tok_valid    = (fill_reg != '0);
    assign tok_item     = mem_reg[rd_ptr_reg];
    assign pop          = tok_valid && tok_ready;
    assign status.room  = (fill_reg <= (PW+1)'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (PW+1)'(push.count) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
    end

endmodule

// ----- rtl/core/pl0_lexer_tokenizer.sv -----
// Top level of the PL/0 lexer: configuration registers, scanner and result queue.
//
// Usage:
//   Feed source bytes on the char channel (char_valid/char_ready/char_item), one byte
//   per item. An item with end_of_input set flushes the pending lexeme and returns
//   the scanner to its starting state; its char_in is ignored.
//   Tokens leave on the tok channel (tok_valid/tok_ready/tok_item). One input item
//   yields zero, one or two tokens; last_of_run marks the final token of an item.
//   An item's tokens enter the queue as the item is taken and leave behind earlier tokens.
//   Throughput: one byte per cycle while char_ready is high. The scanner updates its
//   state in the accept cycle and writes its tokens into a four-entry queue; a long
//   run of items that give two tokens each fills the queue faster than it drains.
//   char_ready drops while the queue has fewer than two free entries.
//   Stall: while tok_ready is low the queue holds its tokens and input keeps
//   flowing until fewer than two queue entries are free; nothing is dropped.
//   Reset: scanner in normal mode with no pending lexeme, queue empty,
//   ident_max_len 11, number_max_digits 5.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 identifier
//   limit, 1 digit limit) at the clock edge; write only while the block is idle.
module pl0_lexer_tokenizer #(
    parameter int KEYWORD_CHARS = 9,
    parameter int LENGTH_LIMIT  = 255
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  pl0lex_pkg::char_item_t  char_item,
    output logic                    tok_valid,
    input  logic                    tok_ready,
    output pl0lex_pkg::token_item_t tok_item,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [5:0]              cfg_data
);

    logic [5:0] ident_max_len_reg;
    logic [3:0] number_max_digits_reg;

    pl0lex_pkg::cfg_t         cfg;
    pl0lex_pkg::push_t        push;
    pl0lex_pkg::fifo_status_t fifo_status;
    logic                     step;

    // Limit registers; writes must land only while idle, a rule on the user that the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_max_len_reg     <= pl0lex_pkg::IDENT_MAX_RESET;
            number_max_digits_reg <= pl0lex_pkg::NUMBER_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pl0lex_pkg::CFG_IDENT_MAX:  ident_max_len_reg     <= cfg_data;
                pl0lex_pkg::CFG_NUMBER_MAX: number_max_digits_reg <= cfg_data[3:0];
                default:                    ident_max_len_reg     <= ident_max_len_reg;
            endcase
        end
    end

    assign cfg.ident_max_len     = ident_max_len_reg;
    assign cfg.number_max_digits = number_max_digits_reg;

    // Accept a byte whenever the queue can absorb the worst case of two tokens
    assign char_ready = fifo_status.room;
    assign step       = char_valid && char_ready;

    pl0lex_scanner #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_LIMIT  (LENGTH_LIMIT)
    ) u_scanner (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (char_item),
        .cfg   (cfg),
        .push  (push)
    );

    pl0lex_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item),
        .status    (fifo_status)
    );

    // Input stalls only when tokens are queued
    a_stall_has_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> tok_valid)
        else $error("input stalled with an empty result queue");

    // Tokens appear only for an accepted item
    a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> step)
        else $error("tokens produced without an accepted item");

    // After a push the queue offers a token in the next cycle
    a_push_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |=> tok_valid)
        else $error("pushed token not offered");

    // Only the second of a pair carries the end-of-run mark
    a_pair_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
        else $error("wrong last_of_run marks on a token pair");

endmodule
